### hdl/kst_pkg.sv
// Shared types, key codes and the key translation ROMs of the scancode translator.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package kst_pkg;

   // compose buffer geometry
   localparam int BUF_DEPTH  = 5;
   localparam int BUF_ADDR_W = $clog2(BUF_DEPTH);
   localparam int BUF_CNT_W  = $clog2(BUF_DEPTH + 1);

   typedef logic [BUF_ADDR_W-1:0] buf_addr_type;
   typedef logic [BUF_CNT_W-1:0]  buf_count_type;

   // key codes (press form; release adds the up flag)
   localparam logic [7:0] UP_FLAG  = 8'h80;
   localparam logic [7:0] K_LCTRL  = 8'd2;
   localparam logic [7:0] K_RCTRL  = 8'd85;
   localparam logic [7:0] K_LSHIFT = 8'd5;
   localparam logic [7:0] K_RSHIFT = 8'd4;
   localparam logic [7:0] K_CAPS   = 8'd3;
   localparam logic [7:0] K_LALT   = 8'd83;
   localparam logic [7:0] K_RALT   = 8'd84;
   localparam logic [7:0] K_NUM    = 8'd106;

   // character handling constants
   localparam logic [7:0] CASE_BIT   = 8'h20;
   localparam logic [7:0] CTRL_MASK  = 8'h1f;
   localparam logic [7:0] ASCII_LO_A = 8'h61;
   localparam logic [7:0] ASCII_LO_Z = 8'h7a;
   localparam logic [7:0] ASCII_UP_X = 8'h58;

   // result codes
   localparam logic       DEST_KEYBOARD = 1'b0;
   localparam logic       DEST_LED      = 1'b1;
   localparam logic [1:0] KIND_PLAIN    = 2'd0;
   localparam logic [1:0] KIND_PAIR     = 2'd1;
   localparam logic [1:0] KIND_HEX      = 2'd2;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_FIRST  = 3'd1,
      PH_SECOND = 3'd2,
      PH_HEX_1  = 3'd3,
      PH_HEX_2  = 3'd4,
      PH_HEX_3  = 3'd5,
      PH_HEX_4  = 3'd6
   } compose_phase_type;

   typedef enum logic [1:0] {
      JOB_CHAR    = 2'd0,
      JOB_LED     = 2'd1,
      JOB_COMPOSE = 2'd2
   } job_kind_type;

   // one scancode's worth of pending output
   typedef struct packed {
      job_kind_type  kind;
      buf_count_type len;
      logic [1:0]    compose_kind;
      logic [7:0]    val0;
      logic [7:0]    val1;
   } job_desc_type;

   // LED command pair: {byte0, byte1}
   function automatic logic [15:0] led_command(input logic [10:0] extra,
                                               input logic num, input logic caps);
      logic [10:0] b;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      b     = {extra[10:2], caps, num};
      byte0 = {1'b0, b[1], b[0], 1'b0, 1'b1, b[10], b[9], 1'b0};
      byte1 = {2'b00, b[5:2], 2'b01};
      return {byte0, byte1};
   endfunction

   // key ROM: bit 8 marks an unused key; shifted selects the shifted table
   function automatic logic [8:0] key_rom(input logic [6:0] key, input logic shifted);
      logic [7:0] p;
      logic [7:0] s;
      logic       nk;
      nk = 1'b0;
      p  = 8'h00;
      s  = 8'h00;
      unique case (key)
         7'd0:   begin p = 8'h00; s = 8'h00; end
         7'd1:   begin p = 8'h01; s = 8'h01; end
         7'd2:   begin p = 8'h02; s = 8'h02; end
         7'd3:   begin p = 8'h03; s = 8'h03; end
         7'd4:   begin p = 8'h04; s = 8'h04; end
         7'd5:   begin p = 8'h05; s = 8'h05; end
         7'd6:   begin p = 8'h1b; s = 8'h1b; end
         7'd7:   begin p = 8'h31; s = 8'h21; end
         7'd8:   begin p = 8'h09; s = 8'h09; end
         7'd9:   begin p = 8'h71; s = 8'h51; end
         7'd10:  begin p = 8'h61; s = 8'h41; end
         7'd11:  begin p = 8'h73; s = 8'h53; end
         7'd12:  begin p = 8'h0c; s = 8'h0c; end
         7'd13:  begin p = 8'h32; s = 8'h40; end
         7'd14:  begin p = 8'h33; s = 8'h23; end
         7'd15:  begin p = 8'h77; s = 8'h57; end
         7'd16:  begin p = 8'h65; s = 8'h45; end
         7'd17:  begin p = 8'h64; s = 8'h44; end
         7'd18:  begin p = 8'h66; s = 8'h46; end
         7'd19:  begin p = 8'h7a; s = 8'h5a; end
         7'd20:  begin p = 8'h78; s = 8'h58; end
         7'd21:  begin p = 8'h34; s = 8'h24; end
         7'd22:  begin p = 8'h35; s = 8'h25; end
         7'd23:  begin p = 8'h72; s = 8'h52; end
         7'd24:  begin p = 8'h74; s = 8'h54; end
         7'd25:  begin p = 8'h67; s = 8'h47; end
         7'd26:  begin p = 8'h68; s = 8'h48; end
         7'd27:  begin p = 8'h63; s = 8'h43; end
         7'd28:  begin p = 8'h76; s = 8'h56; end
         7'd29:  begin p = 8'h36; s = 8'h5e; end
         7'd30:  begin p = 8'h37; s = 8'h26; end
         7'd31:  begin p = 8'h79; s = 8'h59; end
         7'd32:  begin p = 8'h75; s = 8'h55; end
         7'd33:  begin p = 8'h6a; s = 8'h4a; end
         7'd34:  begin p = 8'h6b; s = 8'h4b; end
         7'd35:  begin p = 8'h62; s = 8'h42; end
         7'd36:  begin p = 8'h6e; s = 8'h4e; end
         7'd37:  begin p = 8'h38; s = 8'h2a; end
         7'd38:  begin p = 8'h39; s = 8'h28; end
         7'd39:  begin p = 8'h69; s = 8'h49; end
         7'd40:  begin p = 8'h6f; s = 8'h4f; end
         7'd41:  begin p = 8'h6c; s = 8'h4c; end
         7'd42:  begin p = 8'h3b; s = 8'h3a; end
         7'd43:  begin p = 8'h6d; s = 8'h4d; end
         7'd44:  begin p = 8'h2c; s = 8'h3c; end
         7'd45:  begin p = 8'h30; s = 8'h29; end
         7'd46:  begin p = 8'h2d; s = 8'h5f; end
         7'd47:  begin p = 8'h70; s = 8'h50; end
         7'd48:  begin p = 8'h5b; s = 8'h7b; end
         7'd49:  begin p = 8'h27; s = 8'h22; end
         7'd50:  begin p = 8'h0a; s = 8'h0a; end
         7'd51:  begin p = 8'h2e; s = 8'h3e; end
         7'd52:  begin p = 8'h2f; s = 8'h3f; end
         7'd53:  begin p = 8'h3d; s = 8'h2b; end
         7'd54:  begin p = 8'h60; s = 8'h7e; end
         7'd55:  begin p = 8'h5d; s = 8'h7d; end
         7'd56:  begin p = 8'h5c; s = 8'h7c; end
         7'd57:  begin p = 8'h31; s = 8'h31; end
         7'd58:  begin p = 8'h30; s = 8'h30; end
         7'd59:  begin p = 8'h3b; s = 8'h3b; end
         7'd60:  begin p = 8'h08; s = 8'h08; end
         7'd61:  begin p = 8'h7f; s = 8'h7f; end
         7'd62:  begin p = 8'h34; s = 8'h34; end
         7'd63:  begin p = 8'h32; s = 8'h32; end
         7'd64:  begin p = 8'h33; s = 8'h33; end
         7'd65:  begin p = 8'h2e; s = 8'h2e; end
         7'd66:  begin p = 8'h37; s = 8'h37; end
         7'd67:  begin p = 8'h38; s = 8'h38; end
         7'd68:  begin p = 8'h35; s = 8'h35; end
         7'd69:  begin p = 8'h36; s = 8'h36; end
         7'd70:  begin p = 8'h46; s = 8'h46; end
         7'd71:  begin p = 8'h47; s = 8'h47; end
         7'd72:  begin p = 8'h80; s = 8'h80; end
         7'd73:  begin p = 8'h80; s = 8'h80; end
         7'd74:  begin p = 8'h39; s = 8'h39; end
         7'd75:  begin p = 8'h2d; s = 8'h2d; end
         7'd76:  begin p = 8'h4c; s = 8'h4c; end
         7'd77:  begin p = 8'h4d; s = 8'h4d; end
         7'd78:  begin p = 8'h4e; s = 8'h4e; end
         7'd79:  begin p = 8'h80; s = 8'h80; end
         7'd81:  begin p = 8'h0a; s = 8'h0a; end
         7'd82:  begin p = 8'h20; s = 8'h20; end
         7'd83:  begin p = 8'h53; s = 8'h53; end
         7'd84:  begin p = 8'h54; s = 8'h54; end
         7'd85:  begin p = 8'h55; s = 8'h55; end
         7'd106: begin p = 8'h6a; s = 8'h6a; end
         7'd107: begin p = 8'h2f; s = 8'h2f; end
         7'd108: begin p = 8'h2a; s = 8'h2a; end
         7'd109: begin p = 8'h2b; s = 8'h2b; end
         7'd110: begin p = 8'h6e; s = 8'h6e; end
         default: nk = 1'b1;
      endcase
      return {nk, shifted ? s : p};
   endfunction

endpackage

`default_nettype wire

### hdl/kst_buffer_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; holds the compose key buffer for the top level.
`timescale 1ns / 1ps
`default_nettype none

module kst_buffer_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 5,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port; data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hdl/keyboard_scancode_translator_unit.sv
// Keyboard scancode translator: modifier/lock tracking, key ROM lookup, compose capture.
// First result path: job register, pending stage, then the output register.
// Throughput: one result per cycle unless the output stalls; a new scancode waits for the
// last result of the job before it, so those with zero or one result go in every cycle.
// Compose keys pass through the buffer RAM (one read port), one entry per unstalled cycle.
// Reset (synchronous): clears modifiers, locks, compose phase and all valids; RAM untouched.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_scancode_translator_unit
   import kst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_scancode,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_destination,
   output logic [7:0]       rsp_value,
   output logic [1:0]       rsp_compose_kind,
   output logic             rsp_last,
   input  wire logic        csr_write_enable,
   input  wire logic [10:0] csr_write_data
);

   // state registers
   logic [10:0]       led_extra_ff;
   logic              shift_held_ff, shift_held_in;
   logic              control_held_ff, control_held_in;
   logic              caps_on_ff, caps_on_in;
   logic              num_on_ff, num_on_in;
   compose_phase_type compose_phase_ff, compose_phase_in;

   // emitter job
   logic          job_active_ff, job_active_in;
   job_desc_type  job_ff, job_in;
   buf_addr_type  job_idx_ff, job_idx_in;

   // pending stage (RAM read data stage)
   logic       pend_valid_ff, pend_valid_in;
   logic       pend_dest_ff;
   logic [1:0] pend_kind_ff;
   logic       pend_last_ff;
   logic       pend_from_mem_ff;
   logic [7:0] pend_val_ff;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_dest_ff;
   logic [7:0] rsp_value_ff;
   logic [1:0] rsp_kind_ff;
   logic       rsp_last_ff;

   logic         req_accept;
   logic         pend_move;
   logic         issue;
   logic         issue_last;
   logic         mem_we;
   buf_addr_type mem_waddr;
   logic [7:0]   mem_wdata;
   logic [7:0]   mem_q;

   logic [8:0]  rom_word;
   logic [7:0]  ch_case;
   logic [7:0]  ch;
   logic [15:0] led_pair;

   // pipeline flow control
   assign pend_move  = pend_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue      = job_active_ff && (!pend_valid_ff || pend_move);
   assign issue_last = issue && (buf_count_type'(job_idx_ff) == job_ff.len - buf_count_type'(1));
   assign req_stall  = job_active_ff && !issue_last;
   assign req_accept = req_valid && !req_stall;

   // key lookup and character shaping
   always_comb begin
      rom_word = key_rom(req_scancode[6:0], shift_held_ff);
      if (caps_on_ff && rom_word[7:0] >= ASCII_LO_A && rom_word[7:0] <= ASCII_LO_Z) begin
         ch_case = rom_word[7:0] & ~CASE_BIT;
      end else begin
         ch_case = rom_word[7:0];
      end
      ch = control_held_ff ? (ch_case & CTRL_MASK) : ch_case;
   end

   // scancode decode: state update, buffer write and job setup
   always_comb begin
      shift_held_in    = shift_held_ff;
      control_held_in  = control_held_ff;
      caps_on_in       = caps_on_ff;
      num_on_in        = num_on_ff;
      compose_phase_in = compose_phase_ff;
      mem_we           = 1'b0;
      mem_waddr        = '0;
      mem_wdata        = ch;
      led_pair         = '0;
      job_in           = '{kind: JOB_CHAR, len: '0, compose_kind: KIND_PLAIN,
                           val0: ch, val1: 8'h00};
      job_in.len       = '0;
      if (req_accept) begin
         priority if (req_scancode == K_LCTRL || req_scancode == K_RCTRL) begin
            control_held_in = 1'b1;
         end else if (req_scancode == (UP_FLAG | K_LCTRL) ||
                      req_scancode == (UP_FLAG | K_RCTRL)) begin
            control_held_in = 1'b0;
         end else if (req_scancode == K_LSHIFT || req_scancode == K_RSHIFT) begin
            shift_held_in = 1'b1;
         end else if (req_scancode == (UP_FLAG | K_LSHIFT) ||
                      req_scancode == (UP_FLAG | K_RSHIFT)) begin
            shift_held_in = 1'b0;
         end else if (req_scancode == K_NUM) begin
            num_on_in   = !num_on_ff;
            led_pair    = led_command(led_extra_ff, !num_on_ff, caps_on_ff);
            job_in.kind = JOB_LED;
            job_in.len  = buf_count_type'(2);
            job_in.val0 = led_pair[15:8];
            job_in.val1 = led_pair[7:0];
         end else if (req_scancode == K_CAPS) begin
            caps_on_in  = !caps_on_ff;
            led_pair    = led_command(led_extra_ff, num_on_ff, !caps_on_ff);
            job_in.kind = JOB_LED;
            job_in.len  = buf_count_type'(2);
            job_in.val0 = led_pair[15:8];
            job_in.val1 = led_pair[7:0];
         end else if (req_scancode == K_LALT || req_scancode == K_RALT) begin
            compose_phase_in = PH_FIRST;
         end else if (req_scancode[7] || rom_word[8]) begin
            // other releases and unused keys: nothing
         end else begin
            unique case (compose_phase_ff)
               PH_FIRST: begin
                  mem_we           = 1'b1;
                  mem_waddr        = buf_addr_type'(0);
                  compose_phase_in = (ch == ASCII_UP_X) ? PH_HEX_1 : PH_SECOND;
               end
               PH_SECOND: begin
                  mem_we              = 1'b1;
                  mem_waddr           = buf_addr_type'(1);
                  compose_phase_in    = PH_IDLE;
                  job_in.kind         = JOB_COMPOSE;
                  job_in.len          = buf_count_type'(2);
                  job_in.compose_kind = KIND_PAIR;
               end
               PH_HEX_1, PH_HEX_2, PH_HEX_3: begin
                  mem_we           = 1'b1;
                  mem_waddr        = buf_addr_type'(compose_phase_ff - 3'd2);
                  compose_phase_in = compose_phase_type'(compose_phase_ff + 3'd1);
               end
               PH_HEX_4: begin
                  mem_we              = 1'b1;
                  mem_waddr           = buf_addr_type'(4);
                  compose_phase_in    = PH_IDLE;
                  job_in.kind         = JOB_COMPOSE;
                  job_in.len          = buf_count_type'(5);
                  job_in.compose_kind = KIND_HEX;
               end
               default: begin
                  // no sequence, or the unreachable phase
                  compose_phase_in = PH_IDLE;
                  job_in.len       = buf_count_type'(1);
               end
            endcase
         end
      end
   end

   // job tracking
   always_comb begin
      job_active_in = job_active_ff;
      job_idx_in    = job_idx_ff;
      if (issue) begin
         job_idx_in = buf_addr_type'(job_idx_ff + buf_addr_type'(1));
      end
      if (issue_last) begin
         job_active_in = 1'b0;
      end
      if (req_accept && job_in.len != '0) begin
         job_active_in = 1'b1;
         job_idx_in    = '0;
      end
   end

   assign pend_valid_in = issue ? 1'b1 : (pend_move ? 1'b0 : pend_valid_ff);
   assign rsp_valid_in  = pend_move ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         led_extra_ff     <= '0;
         shift_held_ff    <= 1'b0;
         control_held_ff  <= 1'b0;
         caps_on_ff       <= 1'b0;
         num_on_ff        <= 1'b0;
         compose_phase_ff <= PH_IDLE;
         job_active_ff    <= 1'b0;
         job_idx_ff       <= '0;
         pend_valid_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            led_extra_ff <= csr_write_data;
         end
         shift_held_ff    <= shift_held_in;
         control_held_ff  <= control_held_in;
         caps_on_ff       <= caps_on_in;
         num_on_ff        <= num_on_in;
         compose_phase_ff <= compose_phase_in;
         job_active_ff    <= job_active_in;
         job_idx_ff       <= job_idx_in;
         pend_valid_ff    <= pend_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept && job_in.len != '0) begin
         job_ff <= job_in;
      end
      if (issue) begin
         pend_dest_ff     <= (job_ff.kind == JOB_LED) ? DEST_LED : DEST_KEYBOARD;
         pend_kind_ff     <= job_ff.compose_kind;
         pend_last_ff     <= issue_last;
         pend_from_mem_ff <= (job_ff.kind == JOB_COMPOSE);
         pend_val_ff      <= job_idx_ff[0] ? job_ff.val1 : job_ff.val0;
      end
      if (pend_move) begin
         rsp_dest_ff  <= pend_dest_ff;
         rsp_value_ff <= pend_from_mem_ff ? mem_q : pend_val_ff;
         rsp_kind_ff  <= pend_kind_ff;
         rsp_last_ff  <= pend_last_ff;
      end
   end

   // compose key buffer
   kst_buffer_ram #(
      .WIDTH (8),
      .DEPTH (BUF_DEPTH)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (issue && job_ff.kind == JOB_COMPOSE),
      .rd_addr (job_idx_ff),
      .rd_data (mem_q)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_destination  = rsp_dest_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_compose_kind = rsp_kind_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

`default_nettype wire
